### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared types of the polar SC decoder
// Payload structs of both channels and the op code of the node unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

   localparam int CHAN_W = 8;
   localparam int POS_W  = 6;
   localparam int MASK_W = 64;

   typedef struct packed {
      logic signed [CHAN_W-1:0] channel_llr;
      logic                     block_end;
   } req_type;

   typedef struct packed {
      logic             decoded_bit;
      logic [POS_W-1:0] bit_position;
      logic             was_frozen;
      logic             final_bit;
   } rsp_type;

   typedef struct packed {
      logic use_g;
      logic psum;
   } node_op_type;

endpackage

### src/psc_node_unit.sv
// ----------------------------------------------------------------------------
// psc_node_unit: min-sum f / sign-controlled g with saturation
// Combines two child LLRs into one parent LLR of the same width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_node_unit #(
   parameter int LLR_W = 10
) (
   input  logic signed [LLR_W-1:0] llr_a,
   input  logic signed [LLR_W-1:0] llr_b,
   input  psc_pkg::node_op_type    op,
   output logic signed [LLR_W-1:0] llr_out
);

   localparam logic signed [LLR_W+1:0] SAT_MAX = (LLR_W+2)'((1 << (LLR_W-1)) - 1);
   localparam logic signed [LLR_W+1:0] SAT_MIN = -SAT_MAX - (LLR_W+2)'(1);

   logic signed [LLR_W+1:0] a_ext;
   logic signed [LLR_W+1:0] b_ext;
   logic signed [LLR_W+1:0] mag_a;
   logic signed [LLR_W+1:0] mag_b;
   logic signed [LLR_W+1:0] mag_min;
   logic signed [LLR_W+1:0] raw;

   always_comb begin
      a_ext   = (LLR_W+2)'(llr_a);
      b_ext   = (LLR_W+2)'(llr_b);
      mag_a   = a_ext[LLR_W+1] ? -a_ext : a_ext;
      mag_b   = b_ext[LLR_W+1] ? -b_ext : b_ext;
      mag_min = (mag_a < mag_b) ? mag_a : mag_b;
      if (op.use_g) begin
         raw = op.psum ? (a_ext - b_ext) : (a_ext + b_ext);
      end else if (llr_a == '0 || llr_b == '0) begin
         raw = '0;
      end else begin
         raw = (llr_a[LLR_W-1] == llr_b[LLR_W-1]) ? mag_min : -mag_min;
      end
      if (raw > SAT_MAX) begin
         llr_out = SAT_MAX[LLR_W-1:0];
      end else if (raw < SAT_MIN) begin
         llr_out = SAT_MIN[LLR_W-1:0];
      end else begin
         llr_out = raw[LLR_W-1:0];
      end
   end

endmodule

### src/polar_sc_decoder.sv
// ----------------------------------------------------------------------------
// polar_sc_decoder: polar-code successive cancellation decoder, min-sum
// Loads channel LLRs, then decides every codeword position in order.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  psc_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  psc_pkg::rsp_type
//   csr      in         csr_write_enable     csr_write_data (frozen mask)
//
// Loading stores each accepted LLR, up to one block. Decoding walks the node
// tree one node per cycle through the dual-read LLR memory, pausing at each
// level change and between consecutive roots.
// Reset clears control and the frozen mask; memories need no clearing pass.
// req_stall stays high from block_end until the last bit is taken; a stalled
// rsp holds the sequencer before the next root node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polar_sc_decoder #(
   parameter int CODE_LENGTH    = 64,
   parameter int INNER_LLR_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  psc_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output psc_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [psc_pkg::MASK_W-1:0]        csr_write_data
);

   localparam int LOG_LEN   = $clog2(CODE_LENGTH + 1) - 1;
   localparam int BLK_LEN   = 1 << LOG_LEN;
   localparam int IW        = LOG_LEN;
   localparam int LW        = $clog2(LOG_LEN + 1);
   localparam int LVW       = $clog2(LOG_LEN);
   localparam int W         = INNER_LLR_BITS;
   localparam int AW        = LVW + IW;
   localparam int LLR_DEPTH = LOG_LEN * BLK_LEN;

   logic [psc_pkg::MASK_W-1:0]       frozen_ff;
   logic [psc_pkg::CHAN_W-1:0]       chan_mem [BLK_LEN];
   logic [W-1:0]                     llr_mem [LLR_DEPTH];
   logic [psc_pkg::CHAN_W-1:0]       chan_rd_a_ff, chan_rd_b_ff;
   logic [W-1:0]                     llr_rd_a_ff, llr_rd_b_ff;
   logic [BLK_LEN-1:0]               dec_ff;
   logic [IW:0]                      load_count_ff;
   logic                             busy_ff;
   logic                             seq_run_ff, seq_run_in;
   logic                             bubble_ff, bubble_in;
   logic [IW-1:0]                    bit_ff, bit_in;
   logic [LW-1:0]                    lvl_ff, lvl_in;
   logic [IW-1:0]                    m_ff, m_in;

   logic                             e_valid_ff, e_root_ff, e_chan_ff, e_g_ff;
   logic [AW-1:0]                    e_waddr_ff;
   logic [IW-1:0]                    e_bit_ff, e_need_ff, e_jm1_ff;
   logic [LW-1:0]                    e_d_ff;

   logic                             rsp_valid_ff;
   psc_pkg::rsp_type                 rsp_ff;

   logic                             req_take, rsp_take, start;
   logic                             cur_root, root_block, issue, lvl_last;
   logic [LW-1:0]                    cur_d;
   logic [IW-1:0]                    cur_j, cur_off, half, c_a, c_b, need;
   logic [IW:0]                      lvl_count;
   logic [LVW-1:0]                   clvl;
   logic [IW-1:0]                    nxt_bit;
   logic [LW-1:0]                    nxt_lvl;
   int                               tzv;
   logic signed [W-1:0]              op_a, op_b, node_llr;
   psc_pkg::node_op_type             op;
   logic                             psum, frz, dec_bit;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign start     = req_take && req_payload.block_end;
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff <= '0;
      end else if (csr_write_enable) begin
         frozen_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && load_count_ff < (IW+1)'(BLK_LEN)) begin
         chan_mem[load_count_ff[IW-1:0]] <= req_payload.channel_llr;
      end
      chan_rd_a_ff <= chan_mem[~c_a];
      chan_rd_b_ff <= chan_mem[~c_b];
   end

   always_ff @(posedge clock) begin
      if (e_valid_ff) begin
         llr_mem[e_waddr_ff] <= node_llr;
      end
      llr_rd_a_ff <= llr_mem[{clvl, c_a}];
      llr_rd_b_ff <= llr_mem[{clvl, c_b}];
   end

   always_comb begin
      cur_root   = (lvl_ff == LW'(LOG_LEN));
      cur_d      = LW'(LOG_LEN) - lvl_ff;
      cur_j      = bit_ff >> cur_d;
      cur_off    = IW'(m_ff << lvl_ff);
      half       = IW'((IW+1)'(1) << (lvl_ff - LW'(1)));
      c_a        = cur_off + (cur_j >> 1);
      c_b        = c_a + half;
      clvl       = (lvl_ff >= LW'(2)) ? LVW'(lvl_ff - LW'(2)) : '0;
      lvl_count  = (IW+1)'(BLK_LEN) >> lvl_ff;
      lvl_last   = ({1'b0, m_ff} == lvl_count - (IW+1)'(1));
      root_block = (e_valid_ff && e_root_ff) || (rsp_valid_ff && rsp_stall);
      issue      = seq_run_ff && !bubble_ff && !(cur_root && root_block);
      for (int p = 0; p < LOG_LEN; p++) begin
         need[p] = (LW'(p) < cur_d) && !cur_off[LOG_LEN-1-p];
      end
      nxt_bit = bit_ff + IW'(1);
      tzv     = LOG_LEN - 1;
      for (int p = LOG_LEN - 1; p >= 0; p--) begin
         if (nxt_bit[p]) begin
            tzv = p;
         end
      end
      nxt_lvl = LW'(LOG_LEN - tzv);
   end

   always_comb begin
      seq_run_in = seq_run_ff;
      bubble_in  = 1'b0;
      bit_in     = bit_ff;
      lvl_in     = lvl_ff;
      m_in       = m_ff;
      if (start) begin
         seq_run_in = 1'b1;
         bit_in     = '0;
         lvl_in     = LW'(1);
         m_in       = '0;
      end else if (issue) begin
         if (!lvl_last) begin
            m_in = m_ff + IW'(1);
         end else if (!cur_root) begin
            lvl_in    = lvl_ff + LW'(1);
            m_in      = '0;
            bubble_in = 1'b1;
         end else if (bit_ff == IW'(BLK_LEN - 1)) begin
            seq_run_in = 1'b0;
         end else begin
            bit_in = nxt_bit;
            lvl_in = nxt_lvl;
            m_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_run_ff    <= 1'b0;
         bubble_ff     <= 1'b0;
         busy_ff       <= 1'b0;
         load_count_ff <= '0;
         e_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_run_ff <= seq_run_in;
         bubble_ff  <= bubble_in;
         e_valid_ff <= issue;
         if (start) begin
            busy_ff       <= 1'b1;
            load_count_ff <= '0;
         end else begin
            if (rsp_take && rsp_ff.final_bit) begin
               busy_ff <= 1'b0;
            end
            if (req_take && load_count_ff < (IW+1)'(BLK_LEN)) begin
               load_count_ff <= load_count_ff + (IW+1)'(1);
            end
         end
         if (e_valid_ff && e_root_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bit_ff     <= bit_in;
      lvl_ff     <= lvl_in;
      m_ff       <= m_in;
      e_root_ff  <= cur_root;
      e_chan_ff  <= (lvl_ff == LW'(1));
      e_g_ff     <= cur_j[0];
      e_waddr_ff <= {LVW'(lvl_ff - LW'(1)), cur_off + cur_j};
      e_bit_ff   <= bit_ff;
      e_need_ff  <= need;
      e_jm1_ff   <= cur_j - IW'(1);
      e_d_ff     <= cur_d;
   end

   always_comb begin
      psum = 1'b0;
      for (int q = 0; q < BLK_LEN; q++) begin
         if (((IW'(q) >> e_d_ff) == e_jm1_ff) && ((IW'(q) & e_need_ff) == e_need_ff)) begin
            psum = psum ^ dec_ff[q];
         end
      end
      op.use_g = e_g_ff;
      op.psum  = psum;
      op_a     = e_chan_ff ? W'(signed'(chan_rd_a_ff)) : signed'(llr_rd_a_ff);
      op_b     = e_chan_ff ? W'(signed'(chan_rd_b_ff)) : signed'(llr_rd_b_ff);
      frz      = frozen_ff[psc_pkg::POS_W'(e_bit_ff)];
      dec_bit  = !frz && (node_llr[W-1] || node_llr == '0);
   end

   psc_node_unit #(
      .LLR_W (W)
   ) u_node (
      .llr_a   (op_a),
      .llr_b   (op_b),
      .op      (op),
      .llr_out (node_llr)
   );

   always_ff @(posedge clock) begin
      if (start) begin
         dec_ff <= '0;
      end else if (e_valid_ff && e_root_ff) begin
         dec_ff[e_bit_ff] <= dec_bit;
      end
      if (e_valid_ff && e_root_ff) begin
         rsp_ff.decoded_bit  <= dec_bit;
         rsp_ff.bit_position <= psc_pkg::POS_W'(e_bit_ff);
         rsp_ff.was_frozen   <= frz;
         rsp_ff.final_bit    <= (e_bit_ff == IW'(BLK_LEN - 1));
      end
   end

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("result pending while decoder idle");

   a_root_free: assert property (@(posedge clock) disable iff (reset)
      (e_valid_ff && e_root_ff) |-> !rsp_valid_ff)
      else $error("root decision would overwrite pending result");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      seq_run_ff |-> busy_ff)
      else $error("sequencer running outside decode");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_ff.final_bit) |=> (!busy_ff && !seq_run_ff))
      else $error("decoder still busy after final bit");

endmodule
